/* rtl/core/blpd_pkg.sv */
// Shared types and constants for the button long/double press detector.
// No dependencies; used by the interfaces, blpd_button and the top level.
`default_nettype none

package blpd_pkg;

  localparam int unsigned MASK_BITS = 6;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned TALLY_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [MASK_BITS-1:0] mask_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [TALLY_W-1:0]   tally_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS_MS   = 1'b0,
    CFG_DOUBLE_PRESS_MS = 1'b1
  } cfg_reg_e;

  localparam cfg_data_t LONG_PRESS_RST   = 16'd1000;
  localparam cfg_data_t DOUBLE_PRESS_RST = 16'd300;

  localparam tally_t TALLY_ZERO = 2'd0;
  localparam tally_t TALLY_ONE  = 2'd1;
  localparam tally_t TALLY_MAX  = 2'd3;

  // Flags of one button after a sample
  typedef struct packed {
    logic long_flag;
    logic double_flag;
  } btn_flags_t;

endpackage

`default_nettype wire

/* rtl/core/blpd_in_if.sv */
// Sample channel: valid/ready handshake carrying button levels and a timestamp.
// Depends on blpd_pkg.
`default_nettype none

interface blpd_in_if
  import blpd_pkg::*;
();
  logic  valid;
  logic  ready;
  mask_t raw_levels;
  time_t time_ms;

  modport source (output valid, output raw_levels, output time_ms, input ready);
  modport sink   (input valid, input raw_levels, input time_ms, output ready);
endinterface

`default_nettype wire

/* rtl/core/blpd_out_if.sv */
// Result channel: valid/ready handshake carrying the pressed, long and double masks.
// Depends on blpd_pkg.
`default_nettype none

interface blpd_out_if
  import blpd_pkg::*;
();
  logic  valid;
  logic  ready;
  mask_t pressed_mask;
  mask_t long_mask;
  mask_t double_mask;

  modport source (output valid, output pressed_mask, output long_mask,
                  output double_mask, input ready);
  modport sink   (input valid, input pressed_mask, input long_mask,
                  input double_mask, output ready);
endinterface

`default_nettype wire

/* rtl/core/blpd_button.sv */
// Per-button press tracker: edge detection, long-press timer and double-press count.
// Depends on blpd_pkg.
`default_nettype none

module blpd_button
  import blpd_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             adv_i,
  input  wire             pressed_i,
  input  wire time_t      now_i,
  input  wire cfg_data_t  long_ms_i,
  input  wire cfg_data_t  double_ms_i,
  output btn_flags_t      flags_o
);

  logic   prev_q, prev_d;
  logic   long_q, long_d;
  logic   dbl_q, dbl_d;
  tally_t tally_q, tally_d;
  time_t  start_q, start_d;
  time_t  rel_q, rel_d;

  time_t  since_rel;
  time_t  since_start;
  time_t  long_lim;
  time_t  dbl_lim;

  assign since_rel   = now_i - rel_q;
  assign since_start = now_i - start_q;
  assign long_lim    = {{(TIME_W-CFG_W){1'b0}}, long_ms_i};
  assign dbl_lim     = {{(TIME_W-CFG_W){1'b0}}, double_ms_i};

  // Advance the button state by one sample
  always_comb begin
    prev_d  = pressed_i;
    long_d  = long_q;
    dbl_d   = dbl_q;
    tally_d = tally_q;
    start_d = start_q;
    rel_d   = rel_q;

    if (pressed_i && !prev_q) begin
      start_d = now_i;
      long_d  = 1'b0;
      if (tally_q == TALLY_ONE && since_rel < dbl_lim) begin
        dbl_d   = 1'b1;
        tally_d = TALLY_ZERO;
      end
    end

    if (!pressed_i && prev_q) begin
      rel_d   = now_i;
      tally_d = (tally_q == TALLY_MAX) ? TALLY_MAX : tally_q + TALLY_ONE;
      if (dbl_q) begin
        dbl_d   = 1'b0;
        tally_d = TALLY_ZERO;
      end
    end

    if (pressed_i && prev_q) begin
      if (since_start > long_lim) begin
        long_d  = 1'b1;
        tally_d = TALLY_ZERO;
        dbl_d   = 1'b0;
      end
    end

    // Drop a stale count while the button stays released; a release edge is not checked
    if (!pressed_i && !prev_q && since_rel > dbl_lim) begin
      tally_d = TALLY_ZERO;
    end
  end

  assign flags_o.long_flag   = long_d;
  assign flags_o.double_flag = dbl_d;

  // Commit state when the transaction moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      long_q  <= 1'b0;
      dbl_q   <= 1'b0;
      tally_q <= TALLY_ZERO;
      start_q <= '0;
      rel_q   <= '0;
    end else if (adv_i) begin
      prev_q  <= prev_d;
      long_q  <= long_d;
      dbl_q   <= dbl_d;
      tally_q <= tally_d;
      start_q <= start_d;
      rel_q   <= rel_d;
    end
  end

  // A double press always leaves the count cleared
  a_dbl_clears_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbl_q |-> (tally_q == TALLY_ZERO))
    else $error("double flag set with nonzero press count");

  // Long and double flags exclude each other
  a_long_dbl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(long_q && dbl_q))
    else $error("long and double flags both set");

  // State moves only with a transaction
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(prev_q) && $stable(tally_q) && $stable(rel_q)
                && $stable(start_q)))
    else $error("button state changed without a transaction");

endmodule

`default_nettype wire

/* rtl/core/button_long_double_press_detector.sv */
// Top level of the button long/double press detector: input register, per-button
// trackers and result register. Depends on blpd_pkg, blpd_in_if, blpd_out_if, blpd_button.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+---------------------------------------
//   in_ch    | in  | valid / ready        | raw_levels[5:0], time_ms[31:0]
//   out_ch   | out | valid / ready        | pressed_mask, long_mask, double_mask
//   cfg      | in  | cfg_we_i             | cfg_idx_i, cfg_data_i[15:0]
//
// One sample per cycle sustained while out_ch.ready stays high; an accepted sample is
// captured in the input register, then passes through the per-button compare logic into
// the result register, which drives out_ch.
// The per-button state commits when a sample moves into the result register, so the
// next sample in the input register always sees the updated state.
// A stalled result holds both registers; in_ch.ready drops only when both are full.
// Reset clears all button state and loads long 1000 ms, double 300 ms.
`default_nettype none

module button_long_double_press_detector
  import blpd_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = 6
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  blpd_in_if.sink              in_ch,
  blpd_out_if.source           out_ch
);

  cfg_data_t long_ms_q;
  cfg_data_t dbl_ms_q;

  logic  s1_valid_q;
  mask_t s1_levels_q;
  time_t s1_time_q;

  logic  out_valid_q;
  mask_t pm_q, lm_q, dm_q;

  logic  s2_free;
  logic  adv;
  logic  in_take;

  logic [BUTTON_COUNT-1:0] pressed_nx;
  logic [BUTTON_COUNT-1:0] long_nx;
  logic [BUTTON_COUNT-1:0] dbl_nx;
  mask_t pm_d, lm_d, dm_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms_q <= LONG_PRESS_RST;
      dbl_ms_q  <= DOUBLE_PRESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_LONG_PRESS_MS:   long_ms_q <= cfg_data_i;
        CFG_DOUBLE_PRESS_MS: dbl_ms_q  <= cfg_data_i;
        default:             long_ms_q <= long_ms_q;
      endcase
    end
  end

  // Handshake control
  assign s2_free     = !out_valid_q || out_ch.ready;
  assign adv         = s1_valid_q && s2_free;
  assign in_ch.ready = !s1_valid_q || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_levels_q <= in_ch.raw_levels;
      s1_time_q   <= in_ch.time_ms;
    end
  end

  // Per-button trackers; lines beyond the sample width read as pressed
  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
    btn_flags_t flags;

    if (i < MASK_BITS) begin : g_line
      assign pressed_nx[i] = ~s1_levels_q[i];
    end else begin : g_tied
      assign pressed_nx[i] = 1'b1;
    end

    blpd_button u_button (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .pressed_i   (pressed_nx[i]),
      .now_i       (s1_time_q),
      .long_ms_i   (long_ms_q),
      .double_ms_i (dbl_ms_q),
      .flags_o     (flags)
    );

    assign long_nx[i] = flags.long_flag;
    assign dbl_nx[i]  = flags.double_flag;
  end

  // Gather result masks
  for (genvar j = 0; j < MASK_BITS; j++) begin : g_mask
    if (j < BUTTON_COUNT) begin : g_used
      assign pm_d[j] = pressed_nx[j];
      assign lm_d[j] = long_nx[j];
      assign dm_d[j] = dbl_nx[j];
    end else begin : g_unused
      assign pm_d[j] = 1'b0;
      assign lm_d[j] = 1'b0;
      assign dm_d[j] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm_q <= pm_d;
      lm_q <= lm_d;
      dm_q <= dm_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.pressed_mask = pm_q;
  assign out_ch.long_mask    = lm_q;
  assign out_ch.double_mask  = dm_q;

  // A new result only comes from a held sample
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a sample in the input register");

  // Back-pressure only when the input register is occupied and cannot drain
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (s1_valid_q && out_valid_q && !out_ch.ready))
    else $error("input stalled while a stage was free");

endmodule

`default_nettype wire

/* tb/sv/button_long_double_press_detector_test.sv */
// Self-checking testbench for button_long_double_press_detector: drives samples,
// predicts the masks per sample and checks every result. Depends on blpd_pkg,
// blpd_in_if, blpd_out_if and the detector RTL.
`timescale 1ns / 100ps

module button_long_double_press_detector_test;
  import blpd_pkg::*;

  localparam int unsigned BTN_N        = 6;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned IDLE_PCT     = 30;

  typedef struct packed {
    mask_t levels;
    time_t stamp;
  } sample_t;

  typedef struct packed {
    mask_t press_m;
    mask_t long_m;
    mask_t dbl_m;
  } button_masks_t;

  // Clock, reset and every driven input start at a known value
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_LONG_PRESS_MS;
  cfg_data_t            cfg_data  = '0;
  logic                 smp_valid = 1'b0;
  mask_t                smp_lvls  = '1;
  time_t                smp_stamp = '0;
  logic                 res_ready = 1'b0;
  logic                 calm      = 1'b0;
  int unsigned          err_cnt   = 0;

  sample_t       sample_q[$];
  button_masks_t mask_q[$];

  // Shadow of the detector: thresholds and per-button state
  cfg_data_t cur_long = LONG_PRESS_RST;
  cfg_data_t cur_dbl  = DOUBLE_PRESS_RST;
  logic      btn_held       [BTN_N];
  time_t     btn_press_at   [BTN_N];
  time_t     btn_release_at [BTN_N];
  tally_t    btn_tally      [BTN_N];
  logic      btn_long       [BTN_N];
  logic      btn_dbl        [BTN_N];

  time_t gen_time   = '0;
  mask_t gen_levels = '1;

  blpd_in_if  in_ch ();
  blpd_out_if out_ch ();

  assign in_ch.valid      = smp_valid;
  assign in_ch.raw_levels = smp_lvls;
  assign in_ch.time_ms    = smp_stamp;
  assign out_ch.ready     = res_ready;

  button_long_double_press_detector #(
    .BUTTON_COUNT (BTN_N)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < BTN_N; i++) begin
      btn_held[i]       = 1'b0;
      btn_press_at[i]   = '0;
      btn_release_at[i] = '0;
      btn_tally[i]      = TALLY_ZERO;
      btn_long[i]       = 1'b0;
      btn_dbl[i]        = 1'b0;
    end
  end

  // Advance the shadow state by one sample and return the masks it yields
  function automatic button_masks_t predict_masks(mask_t levels, time_t now);
    button_masks_t m;
    logic          cur;
    logic          prev;
    time_t         gap;
    m = '0;
    for (int i = 0; i < BTN_N; i++) begin
      cur  = ~levels[i];
      prev = btn_held[i];
      if (cur && !prev) begin
        btn_press_at[i] = now;
        btn_long[i]     = 1'b0;
        gap = now - btn_release_at[i];
        if (btn_tally[i] == TALLY_ONE && gap < cur_dbl) begin
          btn_dbl[i]   = 1'b1;
          btn_tally[i] = TALLY_ZERO;
        end
      end
      if (!cur && prev) begin
        btn_release_at[i] = now;
        if (btn_tally[i] != TALLY_MAX) btn_tally[i] = btn_tally[i] + 1'b1;
        if (btn_dbl[i]) begin
          btn_dbl[i]   = 1'b0;
          btn_tally[i] = TALLY_ZERO;
        end
      end
      if (cur && prev) begin
        gap = now - btn_press_at[i];
        if (gap > cur_long) begin
          btn_long[i]  = 1'b1;
          btn_tally[i] = TALLY_ZERO;
          btn_dbl[i]   = 1'b0;
        end
      end
      gap = now - btn_release_at[i];
      if (!cur && gap > cur_dbl) btn_tally[i] = TALLY_ZERO;
      btn_held[i]  = cur;
      m.press_m[i] = cur;
      m.long_m[i]  = btn_long[i];
      m.dbl_m[i]   = btn_dbl[i];
    end
    return m;
  endfunction

  // Driver: predict each accepted transaction, then present the next sample
  always @(posedge clk) begin
    sample_t s;
    if (rst_n) begin
      if (smp_valid && in_ch.ready) begin
        mask_q.push_back(predict_masks(smp_lvls, smp_stamp));
      end
      if (!smp_valid || in_ch.ready) begin
        if (sample_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          s = sample_q.pop_front();
          smp_valid <= 1'b1;
          smp_lvls  <= s.levels;
          smp_stamp <= s.stamp;
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, mask_t exp_v, mask_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    button_masks_t m;
    if (rst_n) begin
      if (out_ch.valid && res_ready) begin
        if (mask_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h %h %h", $time,
                   out_ch.pressed_mask, out_ch.long_mask, out_ch.double_mask);
          err_cnt++;
        end else begin
          m = mask_q.pop_front();
          check_field("pressed_mask", m.press_m, out_ch.pressed_mask);
          check_field("long_mask", m.long_m, out_ch.long_mask);
          check_field("double_mask", m.dbl_m, out_ch.double_mask);
        end
      end
      res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_sample(mask_t levels, time_t stamp);
    sample_t s;
    s.levels = levels;
    s.stamp  = stamp;
    sample_q.push_back(s);
  endtask

  // Hold until nothing is queued, in flight or expected, then let the pipe settle
  task automatic wait_drain();
    @(negedge clk);
    while (sample_q.size() > 0 || smp_valid || mask_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, cfg_data_t val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LONG_PRESS_MS:   cur_long = val;
      CFG_DOUBLE_PRESS_MS: cur_dbl  = val;
      default: ;
    endcase
  endtask

  // Random press/release traffic with time steps mostly scaled to the thresholds, plus large and backward jumps
  task automatic gen_random(int unsigned count, bit settle_midway);
    int unsigned pick;
    int unsigned lim_long;
    int unsigned lim_dbl;
    time_t       step;
    lim_long = cur_long;
    lim_dbl  = cur_dbl;
    @(negedge clk);
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 45)      step = $urandom_range(lim_dbl / 2 + 1);
      else if (pick < 75) step = $urandom_range(lim_long / 3 + 1);
      else if (pick < 85) step = ($urandom_range(1) ? lim_long : lim_dbl)
                                 + $urandom_range(2) - 1;
      else if (pick < 93) step = $urandom;
      else                step = -time_t'($urandom_range(2000));
      gen_time = gen_time + step;
      pick = $urandom_range(99);
      if (pick < 10)      gen_levels = mask_t'($urandom);
      else if (pick < 75) gen_levels = gen_levels ^ mask_t'($urandom & $urandom);
      push_sample(gen_levels, gen_time);
      if (settle_midway && k == count / 2) begin
        wait_drain();
        @(negedge clk);
      end
    end
  endtask

  initial begin
    cfg_data_t   long_set [7];
    cfg_data_t   dbl_set  [7];
    int unsigned cnt_set  [7];
    long_set = '{16'd0, 16'd65535, 16'd0,     16'd65535, 16'd200, 16'd0, 16'd40};
    dbl_set  = '{16'd0, 16'd65535, 16'd65535, 16'd0,     16'd150, 16'd0, 16'd25};
    cnt_set  = '{200,   250,       200,       200,       300,     250,   250};
    long_set[5] = cfg_data_t'($urandom);
    dbl_set[5]  = cfg_data_t'($urandom);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes of both fields with all buttons moving together
    push_sample(6'h3F, 32'h0000_0000);
    push_sample(6'h00, 32'hFFFF_FFFF);
    push_sample(6'h3F, 32'h0000_0005);
    // Double press on button 0, then its release clears the flag
    push_sample(6'h3E, 32'd100);
    push_sample(6'h3E, 32'd200);
    push_sample(6'h3F, 32'd250);
    // Button 1 repeats at exactly the window: no double, tally saturates
    push_sample(6'h3D, 32'd1000);
    push_sample(6'h3F, 32'd1010);
    push_sample(6'h3D, 32'd1310);
    push_sample(6'h3F, 32'd1320);
    push_sample(6'h3D, 32'd1620);
    push_sample(6'h3F, 32'd1630);
    push_sample(6'h3D, 32'd1930);
    push_sample(6'h3F, 32'd1940);
    push_sample(6'h3D, 32'd2240);
    // Long press on buttons 1 and 2, right at and just past the limit
    push_sample(6'h39, 32'd3000);
    push_sample(6'h39, 32'd3240);
    push_sample(6'h39, 32'd3241);
    push_sample(6'h3B, 32'd4001);
    // Long flag survives the release
    push_sample(6'h3F, 32'd4100);
    // Time running backwards around a press and release
    push_sample(6'h3E, 32'd50);
    push_sample(6'h3F, 32'd40);
    push_sample(6'h3E, 32'd30);
    push_sample(6'h2A, 32'h8000_0000);
    push_sample(6'h15, 32'h7FFF_FFFF);

    // Reset thresholds first, with a drain halfway through
    gen_time   = 32'h7FFF_FFFF;
    gen_levels = 6'h15;
    gen_random(250, 1'b1);

    for (int p = 0; p < 7; p++) begin
      wait_drain();
      write_reg(CFG_LONG_PRESS_MS, long_set[p]);
      write_reg(CFG_DOUBLE_PRESS_MS, dbl_set[p]);
      calm = (p == 4);
      if (p == 1) gen_time = 32'hFFFF_0000;
      gen_random(cnt_set[p], 1'b0);
    end

    wait_drain();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/blpd_pkg.sv
rtl/core/blpd_in_if.sv
rtl/core/blpd_out_if.sv
rtl/core/blpd_button.sv
rtl/core/button_long_double_press_detector.sv
tb/sv/button_long_double_press_detector_test.sv
